// ===== rtl/spl_pkg.sv =====
// ============================================================================
// spl_pkg
// Shared constants and codes of the sample player with loop modes.
// ============================================================================
package spl_pkg;

    // Default sizing of the frame store and the position accumulator.
    localparam int DEF_FRAME_DEPTH = 65536;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths.
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 16;
    localparam int RATIO_W    = 20;
    localparam int SPEED_W    = 21;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 18;
    localparam int PEAK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Gains are Q3.14.
    localparam int GAIN_FRAC = 14;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EJECT = 2'd3;

    // Loop mode codes; the unused code behaves as single.
    localparam logic [MODE_W-1:0] LOOP_REPEAT   = 2'd0;
    localparam logic [MODE_W-1:0] LOOP_SINGLE   = 2'd1;
    localparam logic [MODE_W-1:0] LOOP_PINGPONG = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LGAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RGAIN  = 3'd7;

    // Register reset values.
    localparam logic [RATIO_W-1:0] RATIO_RESET = 20'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 18'd16384;

endpackage

// ===== rtl/sample_player_loop_modes.sv =====
// ============================================================================
// sample_player_loop_modes
// Two-channel sample player: frame store, Q position stepping with repeat,
// single and ping-pong looping, gain scaling with saturation.
// ============================================================================
//
// Usage:
// - Input channel (in_valid / in_stall): one beat per item. func selects a
//   tick, a frame write, load done or eject. Every beat yields one result.
// - Output channel (out_valid / out_stall): held left/right samples, the
//   play flag and the peak magnitude, in item order.
// - Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high; the user
//   must write registers only while no item is in flight; the block does not enforce it.
// - Throughput: one item per cycle while the output is not stalled. The position
//   update, frame store write and the synchronous frame store read all happen at
//   the accept edge, so a tick may read a frame written by the item just before it.
// - Pipeline: store read, gain multiply, then round/saturate into the output
//   register, each registered in turn after accept.
// - When the receiver stalls a full output register, the whole pipeline
//   holds and in_stall rises in the same cycle.
// - Reset clears position, play and loaded flags, held samples and peak and sets
//   the forward direction; the frame store holds no reset and needs no clearing pass.
//
module sample_player_loop_modes
    import spl_pkg::*;
#(
    parameter int FRAME_DEPTH = DEF_FRAME_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [FUNC_W-1:0]             func,
    input  logic [INDEX_W-1:0]            write_addr,
    input  logic signed [SAMPLE_BITS-1:0] write_left,
    input  logic signed [SAMPLE_BITS-1:0] write_right,
    input  logic                          start_cmd,
    input  logic                          pause_level,
    input  logic                          stop_level,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          playing,
    output logic [PEAK_W-1:0]             peak_level
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int POS_W  = INDEX_W + FRAC_BITS + 2;
    localparam int SHL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int PROD_W = GAIN_W + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 1;

    // Configuration registers.
    logic [INDEX_W-1:0]       cfg_start_reg;
    logic [INDEX_W-1:0]       cfg_end_reg;
    logic [RATIO_W-1:0]       cfg_ratio_reg;
    logic signed [SPEED_W-1:0] cfg_speed_reg;
    logic [MODE_W-1:0]        cfg_mode_reg;
    logic                     cfg_stereo_reg;
    logic signed [GAIN_W-1:0] cfg_lgain_reg;
    logic signed [GAIN_W-1:0] cfg_rgain_reg;

    // Player state.
    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic                     fwd_reg, fwd_next;
    logic                     play_reg, play_next;
    logic                     loaded_reg, loaded_next;
    logic [SAMPLE_BITS-1:0]   peak_reg, peak_next;

    // Frame store.
    logic signed [SAMPLE_BITS-1:0] left_mem  [FRAME_DEPTH];
    logic signed [SAMPLE_BITS-1:0] right_mem [FRAME_DEPTH];

    // Pipeline stage 1: store read data.
    logic                          s1_valid_reg;
    logic                          s1_upd_reg;
    logic                          s1_play_reg;
    logic [PEAK_W-1:0]             s1_peak_reg;
    logic signed [SAMPLE_BITS-1:0] rd_left_reg;
    logic signed [SAMPLE_BITS-1:0] rd_right_reg;

    // Pipeline stage 2: gain products.
    logic                     s2_valid_reg;
    logic                     s2_upd_reg;
    logic                     s2_play_reg;
    logic [PEAK_W-1:0]        s2_peak_reg;
    logic signed [PROD_W-1:0] prod_l_reg;
    logic signed [PROD_W-1:0] prod_r_reg;

    // Held samples and output register.
    logic signed [SAMPLE_BITS-1:0] held_l_reg, held_l_next;
    logic signed [SAMPLE_BITS-1:0] held_r_reg, held_r_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          out_play_reg;
    logic [PEAK_W-1:0]             out_peak_reg;

    logic advance;
    logic accept;

    // Combinational tick datapath.
    logic signed [POS_W-1:0] b_pos, e_pos, lo_pos, hi_pos;
    logic signed [POS_W-1:0] ratio_ext, ratio_pos, speed_pos, step_pos;
    logic signed [POS_W-1:0] pos_stop, pos_step;
    logic                    up;
    logic                    in_win;
    logic                    play_start, play_run;
    logic                    do_read;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W+INDEX_W-1:0] rd_addr_wide;
    logic [ADDR_W+INDEX_W-1:0] wr_addr_wide;
    logic [SAMPLE_BITS-1:0]  mag_l, mag_r;
    logic [SAMPLE_BITS+PEAK_W-1:0] peak_wide;

    // Round to nearest (half up) at the gain binary point and saturate.
    function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shifted;
        logic signed [SUM_W-1:0] max_val;
        logic signed [SUM_W-1:0] min_val;
        logic signed [SAMPLE_BITS-1:0] res;
        sum     = SUM_W'(prod) + (SUM_W'(1) <<< (GAIN_FRAC - 1));
        shifted = sum >>> GAIN_FRAC;
        max_val = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - SUM_W'(1);
        min_val = -(SUM_W'(1) <<< (SAMPLE_BITS - 1));
        if (shifted > max_val)
        begin
            res = max_val[SAMPLE_BITS-1:0];
        end
        else if (shifted < min_val)
        begin
            res = min_val[SAMPLE_BITS-1:0];
        end
        else
        begin
            res = shifted[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // The pipeline moves as one unit unless a finished result is held.
    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign accept    = in_valid && advance;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_start_reg  <= '0;
            cfg_end_reg    <= '0;
            cfg_ratio_reg  <= RATIO_RESET;
            cfg_speed_reg  <= '0;
            cfg_mode_reg   <= LOOP_REPEAT;
            cfg_stereo_reg <= 1'b0;
            cfg_lgain_reg  <= GAIN_RESET;
            cfg_rgain_reg  <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START:  cfg_start_reg  <= cfg_data[INDEX_W-1:0];
                REG_END:    cfg_end_reg    <= cfg_data[INDEX_W-1:0];
                REG_RATIO:  cfg_ratio_reg  <= cfg_data[RATIO_W-1:0];
                REG_SPEED:  cfg_speed_reg  <= cfg_data[SPEED_W-1:0];
                REG_MODE:   cfg_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_STEREO: cfg_stereo_reg <= cfg_data[0];
                REG_LGAIN:  cfg_lgain_reg  <= cfg_data[GAIN_W-1:0];
                REG_RGAIN:  cfg_rgain_reg  <= cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    // Window bounds and per-tick step, all in position units.
    assign b_pos     = {2'b00, cfg_start_reg, FRAC_BITS'(0)};
    assign e_pos     = {2'b00, cfg_end_reg, FRAC_BITS'(0)};
    assign up        = (cfg_start_reg <= cfg_end_reg);
    assign lo_pos    = up ? b_pos : e_pos;
    assign hi_pos    = up ? e_pos : b_pos;
    assign ratio_ext = {{(POS_W-RATIO_W){1'b0}}, cfg_ratio_reg};
    assign ratio_pos = (ratio_ext <<< SHL) >>> SHR;
    assign speed_pos = $signed({{(POS_W-SPEED_W){cfg_speed_reg[SPEED_W-1]}}, cfg_speed_reg}
                               <<< SHL) >>> SHR;
    assign step_pos  = ((up == fwd_reg) ? ratio_pos : -ratio_pos) + speed_pos;

    // Tick sequence: start, pause/stop, step, window check.
    assign play_start = play_reg || start_cmd;
    assign pos_stop   = stop_level ? (fwd_reg ? b_pos : e_pos) : pos_reg;
    assign play_run   = play_start && !(pause_level || stop_level);
    assign pos_step   = play_run ? pos_stop + step_pos : pos_stop;
    assign in_win     = (pos_step >= lo_pos) && (pos_step <= hi_pos);

    // Frame addresses, zero-extended or cut to the store depth.
    assign rd_addr_wide = {ADDR_W'(0), pos_step[FRAC_BITS +: INDEX_W]};
    assign rd_addr      = rd_addr_wide[ADDR_W-1:0];
    assign wr_addr_wide = {ADDR_W'(0), write_addr};
    assign wr_addr      = wr_addr_wide[ADDR_W-1:0];

    // Sample magnitudes for the peak tracker.
    assign mag_l = write_left[SAMPLE_BITS-1] ? (~write_left + 1'b1) : write_left;
    assign mag_r = write_right[SAMPLE_BITS-1] ? (~write_right + 1'b1) : write_right;

    // Next state of the player for the item at the input.
    always_comb
    begin
        pos_next    = pos_reg;
        fwd_next    = fwd_reg;
        play_next   = play_reg;
        loaded_next = loaded_reg;
        peak_next   = peak_reg;
        do_read     = 1'b0;
        unique case (func)
            FUNC_WRITE:
            begin
                if (mag_l > peak_next)
                begin
                    peak_next = mag_l;
                end
                if (mag_r > peak_next)
                begin
                    peak_next = mag_r;
                end
            end
            FUNC_LOAD:
            begin
                loaded_next = 1'b1;
            end
            FUNC_EJECT:
            begin
                loaded_next = 1'b0;
                play_next   = 1'b0;
            end
            FUNC_TICK:
            begin
                play_next = play_start;
                if (loaded_reg)
                begin
                    play_next = play_run;
                    pos_next  = pos_step;
                    do_read   = play_run && in_win;
                    if (!in_win)
                    begin
                        if (cfg_mode_reg != LOOP_PINGPONG)
                        begin
                            pos_next = b_pos;
                            if (cfg_mode_reg != LOOP_REPEAT)
                            begin
                                play_next = 1'b0;
                            end
                        end
                        else
                        begin
                            pos_next = fwd_reg ? e_pos : b_pos;
                            fwd_next = !fwd_reg;
                        end
                    end
                end
            end
        endcase
    end

    assign peak_wide = {PEAK_W'(0), peak_next};

    // Player state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fwd_reg    <= 1'b1;
            play_reg   <= 1'b0;
            loaded_reg <= 1'b0;
            peak_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            fwd_reg    <= fwd_next;
            play_reg   <= play_next;
            loaded_reg <= loaded_next;
            peak_reg   <= peak_next;
        end
    end

    // Frame store: write on a write beat, synchronous read on a loaded, playing, in-window tick.
    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_WRITE))
        begin
            left_mem[wr_addr]  <= write_left;
            right_mem[wr_addr] <= write_right;
        end
        if (accept && do_read)
        begin
            rd_left_reg  <= left_mem[rd_addr];
            rd_right_reg <= right_mem[rd_addr];
        end
    end

    // Pipeline control bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_upd_reg    <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_upd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s1_upd_reg    <= in_valid && do_read;
            s2_valid_reg  <= s1_valid_reg;
            s2_upd_reg    <= s1_valid_reg && s1_upd_reg;
            out_valid_reg <= s2_valid_reg;
            held_l_reg    <= held_l_next;
            held_r_reg    <= held_r_next;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_play_reg   <= play_next;
            s1_peak_reg   <= peak_wide[PEAK_W-1:0];
            s2_play_reg   <= s1_play_reg;
            s2_peak_reg   <= s1_peak_reg;
            prod_l_reg    <= PROD_W'(cfg_lgain_reg * rd_left_reg);
            prod_r_reg    <= PROD_W'(cfg_rgain_reg *
                             (cfg_stereo_reg ? rd_right_reg : rd_left_reg));
            out_left_reg  <= held_l_next;
            out_right_reg <= held_r_next;
            out_play_reg  <= s2_play_reg;
            out_peak_reg  <= s2_peak_reg;
        end
    end

    // Held samples change only on a tick that read the store.
    assign held_l_next = (s2_valid_reg && s2_upd_reg) ? scale_sat(prod_l_reg) : held_l_reg;
    assign held_r_next = (s2_valid_reg && s2_upd_reg) ? scale_sat(prod_r_reg) : held_r_reg;

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign playing    = out_play_reg;
    assign peak_level = out_peak_reg;

endmodule
